>>> rtl/bscc_pkg.sv
// Shared types, constants and tables for the battery SoC coulomb counter.
`timescale 1ns / 1ps

package bscc_pkg;

  // Field widths
  localparam int CUR_W      = 20;
  localparam int TIME_W     = 32;
  localparam int MV_W       = 16;
  localparam int SOC_W      = 27;
  localparam int WHOLE_W    = 7;
  localparam int CAP_W      = 12;
  localparam int BAND_W     = 17;
  localparam int REST_W     = 20;
  localparam int GATE_W     = 18;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 27;

  // Datapath widths
  localparam int MUL_AW    = 20;
  localparam int MUL_BW    = 27;
  localparam int MUL_PW    = MUL_AW + MUL_BW;
  localparam int ACC_W     = 52;
  localparam int DIV_QW    = 28;
  localparam int DIV_VW    = 20;
  localparam int DIV_STEPS = DIV_QW / 2;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [SOC_W-1:0]  SOC_FULL  = 27'd100000000;
  localparam logic [DIV_VW-1:0] BLEND_DIV = 20'd20;
  localparam logic [DIV_VW-1:0] WHOLE_DIV = 20'd1000000;

  // Open-circuit voltage table (mV to micro-percent)
  localparam int TABLE_POINTS = 11;
  localparam int TABLE_SLOTS  = 16;
  localparam int TABLE_LAST   = (TABLE_POINTS - 1) % TABLE_SLOTS;

  localparam logic [MV_W-1:0] VOLT_MV [TABLE_SLOTS] = '{
    16'd40000, 16'd48000, 16'd51200, 16'd51500, 16'd52000, 16'd52200,
    16'd52300, 16'd52800, 16'd53100, 16'd53600, 16'd54400,
    16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };
  localparam logic [SOC_W-1:0] PCT_UPCT [TABLE_SLOTS] = '{
    27'd0, 27'd10000000, 27'd20000000, 27'd30000000, 27'd40000000,
    27'd50000000, 27'd60000000, 27'd70000000, 27'd80000000, 27'd90000000,
    27'd100000000, 27'd0, 27'd0, 27'd0, 27'd0, 27'd0
  };

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY  = 3'd0,
    CFG_BAND_LOW  = 3'd1,
    CFG_BAND_HIGH = 3'd2,
    CFG_REST_TIME = 3'd3,
    CFG_GATE      = 3'd4,
    CFG_INIT_SOC  = 3'd5
  } cfg_reg_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_DIV_CHARGE,
    OP_APPLY_CHARGE,
    OP_GATE,
    OP_TBL_SEL,
    OP_TBL_MUL,
    OP_DIV_TABLE,
    OP_APPLY_TABLE,
    OP_DIV_BLEND,
    OP_APPLY_BLEND,
    OP_DIV_WHOLE,
    OP_APPLY_WHOLE,
    OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV_CHG,
    ST_WAIT_CHG,
    ST_GATE,
    ST_TBL_SEL,
    ST_TBL_MUL,
    ST_DIV_TBL,
    ST_WAIT_TBL,
    ST_DIV_BLEND,
    ST_WAIT_BLEND,
    ST_DIV_WHOLE,
    ST_WAIT_WHOLE,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic corr_now;
    logic out_busy;
  } dp_status_t;

endpackage

>>> rtl/battery_soc_coulomb_counter_unit.sv
// Top level of the battery SoC coulomb counter with voltage-table correction.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+----------------------------------------
//   cfg     | in        | cfg_wr_en           | cfg_index, cfg_data
//   in      | in        | in_valid / in_stall | current_ma, now_ms, battery_voltage_mv
//   out     | out       | out_valid/out_stall | soc_micro_pct, soc_whole_pct, at_rest,
//           |           |                     | corrected
//
// A sample runs from acceptance to the output register through the shared divider (two
// quotient bits per cycle), which it uses for up to four divisions: twice per sample, and
// four times when the voltage correction runs.
// Reset is synchronous and active high; no clearing pass is needed after it.
// A new sample is accepted while the previous result waits in the output register;
// the block holds in its final state only while that register is still stalled.
`timescale 1ns / 1ps

module battery_soc_coulomb_counter_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [bscc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bscc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [bscc_pkg::CUR_W-1:0]    current_ma,
  input  logic [bscc_pkg::TIME_W-1:0]          now_ms,
  input  logic [bscc_pkg::MV_W-1:0]            battery_voltage_mv,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bscc_pkg::SOC_W-1:0]           soc_micro_pct,
  output logic [bscc_pkg::WHOLE_W-1:0]         soc_whole_pct,
  output logic                                 at_rest,
  output logic                                 corrected
);

  bscc_pkg::dp_cmd_t    cmd;
  bscc_pkg::dp_status_t status;

  bscc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  bscc_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .current_ma         (current_ma),
    .now_ms             (now_ms),
    .battery_voltage_mv (battery_voltage_mv),
    .cmd                (cmd),
    .status             (status),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .soc_micro_pct      (soc_micro_pct),
    .soc_whole_pct      (soc_whole_pct),
    .at_rest            (at_rest),
    .corrected          (corrected)
  );

  // A transaction on the input side always starts a busy period
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // Reported SoC stays within full scale
  a_soc_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (soc_micro_pct <= bscc_pkg::SOC_FULL))
    else $error("SoC above full scale");

  // Whole percent is the truncated micro-percent value
  a_whole_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((34'(soc_whole_pct) * 34'd1000000 <= 34'(soc_micro_pct)) &&
                   (34'(soc_micro_pct) < (34'(soc_whole_pct) + 34'd1) * 34'd1000000)))
    else $error("whole percent disagrees with micro-percent");

  // A correction only happens while the current is stable
  a_corr_rest: assert property (@(posedge clk) disable iff (rst)
    (out_valid && corrected) |-> at_rest)
    else $error("correction applied without rest");

endmodule

>>> rtl/bscc_div.sv
// Iterative restoring divider, two quotient bits per cycle, saturating quotient.
`timescale 1ns / 1ps

module bscc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [bscc_pkg::ACC_W-1:0]         dividend,
  input  logic [bscc_pkg::DIV_VW-1:0]        divisor,
  output logic                               done,
  output logic [bscc_pkg::DIV_QW-1:0]        quotient
);

  logic                              busy;
  logic [bscc_pkg::DIV_CNT_W-1:0]    cnt;
  logic [bscc_pkg::DIV_VW-1:0]       rem;
  logic [bscc_pkg::DIV_VW-1:0]       dsr;
  logic [bscc_pkg::DIV_QW-1:0]       low;
  logic                              sat;
  logic [bscc_pkg::DIV_VW:0]         r1;
  logic [bscc_pkg::DIV_VW:0]         r2;
  logic                              ge1;
  logic                              ge2;
  logic [bscc_pkg::DIV_VW-1:0]       rem1;
  logic [bscc_pkg::DIV_VW-1:0]       rem2;
  logic [bscc_pkg::DIV_QW-1:0]       low1;
  logic [bscc_pkg::DIV_QW-1:0]       low2;

  // Quotient would not fit: report all ones
  assign sat = dividend >= {{(bscc_pkg::ACC_W - bscc_pkg::DIV_VW - bscc_pkg::DIV_QW){1'b0}},
                            divisor, {bscc_pkg::DIV_QW{1'b0}}};

  // Two dependent shift-subtract steps
  always_comb begin
    r1   = {rem, low[bscc_pkg::DIV_QW-1]};
    ge1  = r1 >= {1'b0, dsr};
    rem1 = ge1 ? bscc_pkg::DIV_VW'(r1 - {1'b0, dsr}) : r1[bscc_pkg::DIV_VW-1:0];
    low1 = {low[bscc_pkg::DIV_QW-2:0], ge1};
    r2   = {rem1, low1[bscc_pkg::DIV_QW-1]};
    ge2  = r2 >= {1'b0, dsr};
    rem2 = ge2 ? bscc_pkg::DIV_VW'(r2 - {1'b0, dsr}) : r2[bscc_pkg::DIV_VW-1:0];
    low2 = {low1[bscc_pkg::DIV_QW-2:0], ge2};
  end

  // Sequence the steps and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= bscc_pkg::DIV_CNT_W'(bscc_pkg::DIV_STEPS);
        end
      end else if (busy) begin
        cnt <= cnt - bscc_pkg::DIV_CNT_W'(1);
        if (cnt == bscc_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold partial remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dsr <= divisor;
      if (sat) begin
        low <= '1;
      end else begin
        rem <= dividend[bscc_pkg::DIV_VW+bscc_pkg::DIV_QW-1:bscc_pkg::DIV_QW];
        low <= dividend[bscc_pkg::DIV_QW-1:0];
      end
    end else if (busy) begin
      rem <= rem2;
      low <= low2;
    end
  end

  assign quotient = low;

endmodule

>>> rtl/bscc_dp.sv
// Datapath: configuration, SoC state, shared multiplier, divider and output register.
`timescale 1ns / 1ps

module bscc_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [bscc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bscc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic signed [bscc_pkg::CUR_W-1:0]    current_ma,
  input  logic [bscc_pkg::TIME_W-1:0]          now_ms,
  input  logic [bscc_pkg::MV_W-1:0]            battery_voltage_mv,
  input  bscc_pkg::dp_cmd_t                    cmd,
  output bscc_pkg::dp_status_t                 status,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [bscc_pkg::SOC_W-1:0]           soc_micro_pct,
  output logic [bscc_pkg::WHOLE_W-1:0]         soc_whole_pct,
  output logic                                 at_rest,
  output logic                                 corrected
);

  // Configuration registers
  logic [bscc_pkg::CAP_W-1:0]          cap;
  logic [bscc_pkg::BAND_W-1:0]         band_low;
  logic [bscc_pkg::BAND_W-1:0]         band_high;
  logic [bscc_pkg::REST_W-1:0]         rest_time;
  logic signed [bscc_pkg::GATE_W-1:0]  gate_cur;

  // Persistent state
  logic [bscc_pkg::SOC_W-1:0]          soc;
  logic [bscc_pkg::TIME_W-1:0]         prior_time;
  logic signed [bscc_pkg::CUR_W-1:0]   prior_cur;
  logic                                stable_flag;
  logic [bscc_pkg::TIME_W-1:0]         stable_start;

  // Per-transaction working registers
  logic signed [bscc_pkg::CUR_W-1:0]   cur;
  logic [bscc_pkg::TIME_W-1:0]         now;
  logic [bscc_pkg::MV_W-1:0]           mv;
  logic [bscc_pkg::TIME_W-1:0]         elapsed;
  logic [bscc_pkg::CUR_W-1:0]          mag;
  logic [bscc_pkg::DIV_VW-1:0]         vdiv;
  logic [bscc_pkg::ACC_W-1:0]          acc;
  logic                                corr;
  logic [bscc_pkg::MV_W-1:0]           tbl_num;
  logic [bscc_pkg::MV_W-1:0]           tbl_span;
  logic [bscc_pkg::SOC_W-1:0]          tbl_dpct;
  logic [bscc_pkg::SOC_W-1:0]          tbl_base;
  logic [bscc_pkg::SOC_W-1:0]          tbl_val;
  logic [bscc_pkg::WHOLE_W-1:0]        whole;

  // Combinational values
  logic [bscc_pkg::CUR_W-1:0]          mag_in;
  logic [bscc_pkg::CAP_W-1:0]          cap_eff;
  logic [17:0]                         cap_x;
  logic [17:0]                         vdiv36;
  logic [bscc_pkg::MUL_AW-1:0]         mul_a;
  logic [bscc_pkg::MUL_BW-1:0]         mul_b;
  logic [bscc_pkg::MUL_PW-1:0]         mul_p;
  logic                                div_start;
  logic [bscc_pkg::ACC_W-1:0]          div_dvd;
  logic [bscc_pkg::DIV_VW-1:0]         div_dsr;
  logic                                div_done;
  logic [bscc_pkg::DIV_QW-1:0]         div_q;
  logic signed [29:0]                  soc_base;
  logic signed [29:0]                  dq_s;
  logic signed [29:0]                  soc_s;
  logic [bscc_pkg::SOC_W-1:0]          soc_chg;
  logic signed [bscc_pkg::CUR_W-1:0]   gate_x;
  logic                                cur_gt;
  logic [bscc_pkg::CUR_W:0]            cur_diff;
  logic [bscc_pkg::CUR_W:0]            abs_d;
  logic                                in_band;
  logic [bscc_pkg::TIME_W-1:0]         rest_el;
  logic                                rest_ok;
  logic [30:0]                         soc_x;
  logic [30:0]                         blend_sum;
  logic                                sel_found;
  logic [bscc_pkg::MV_W-1:0]           sel_num;
  logic [bscc_pkg::MV_W-1:0]           sel_span;
  logic [bscc_pkg::SOC_W-1:0]          sel_dpct;
  logic [bscc_pkg::SOC_W-1:0]          sel_base;

  // Sample magnitude and coulomb divisor (capacity of zero acts as one)
  assign mag_in  = current_ma[bscc_pkg::CUR_W-1] ? (~current_ma + 20'd1) : current_ma;
  assign cap_eff = (cap == '0) ? 12'd1 : cap;
  assign cap_x   = {6'd0, cap_eff};
  assign vdiv36  = (cap_x << 5) + (cap_x << 2);

  // Shared multiplier
  always_comb begin
    case (cmd.op)
      bscc_pkg::OP_MUL_LO: begin
        mul_a = mag;
        mul_b = {11'd0, elapsed[15:0]};
      end
      bscc_pkg::OP_MUL_HI: begin
        mul_a = mag;
        mul_b = {11'd0, elapsed[31:16]};
      end
      bscc_pkg::OP_TBL_MUL: begin
        mul_a = {4'd0, tbl_num};
        mul_b = tbl_dpct;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Blend numerator: 19 * soc + table value
  assign soc_x     = {4'd0, soc};
  assign blend_sum = (soc_x << 4) + (soc_x << 1) + soc_x + {4'd0, tbl_val};

  // Route operands to the shared divider
  always_comb begin
    div_start = 1'b0;
    div_dvd   = acc;
    div_dsr   = vdiv;
    case (cmd.op)
      bscc_pkg::OP_DIV_CHARGE: begin
        div_start = 1'b1;
      end
      bscc_pkg::OP_DIV_TABLE: begin
        div_start = 1'b1;
        div_dsr   = {4'd0, tbl_span};
      end
      bscc_pkg::OP_DIV_BLEND: begin
        div_start = 1'b1;
        div_dvd   = {21'd0, blend_sum};
        div_dsr   = bscc_pkg::BLEND_DIV;
      end
      bscc_pkg::OP_DIV_WHOLE: begin
        div_start = 1'b1;
        div_dvd   = {25'd0, soc};
        div_dsr   = bscc_pkg::WHOLE_DIV;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  bscc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  // Apply charge step with clamp to 0..100 percent
  always_comb begin
    soc_base = $signed({3'b000, soc});
    dq_s     = $signed({2'b00, div_q});
    soc_s    = cur[bscc_pkg::CUR_W-1] ? (soc_base + dq_s) : (soc_base - dq_s);
    if (soc_s[29]) begin
      soc_chg = '0;
    end else if (soc_s > $signed({3'b000, bscc_pkg::SOC_FULL})) begin
      soc_chg = bscc_pkg::SOC_FULL;
    end else begin
      soc_chg = soc_s[bscc_pkg::SOC_W-1:0];
    end
  end

  // Gate, band and rest-time checks
  assign gate_x   = $signed({{2{gate_cur[bscc_pkg::GATE_W-1]}}, gate_cur});
  assign cur_gt   = cur > gate_x;
  assign cur_diff = {cur[bscc_pkg::CUR_W-1], cur} - {prior_cur[bscc_pkg::CUR_W-1], prior_cur};
  assign abs_d    = cur_diff[bscc_pkg::CUR_W] ? (~cur_diff + 21'd1) : cur_diff;
  assign in_band  = (abs_d >= {4'd0, band_low}) && (abs_d < {4'd0, band_high});
  assign rest_el  = now - stable_start;
  assign rest_ok  = rest_el > {12'd0, rest_time};

  // Find the table segment; percentages rise with voltage across the table
  always_comb begin
    sel_found = 1'b0;
    sel_num   = '0;
    sel_span  = 16'd1;
    sel_dpct  = '0;
    sel_base  = '0;
    if (mv <= bscc_pkg::VOLT_MV[0]) begin
      sel_base = '0;
    end else if (mv >= bscc_pkg::VOLT_MV[bscc_pkg::TABLE_LAST]) begin
      sel_base = bscc_pkg::SOC_FULL;
    end else begin
      for (int i = 0; i < bscc_pkg::TABLE_SLOTS - 1; i++) begin
        if (!sel_found && (i + 1 < bscc_pkg::TABLE_POINTS) &&
            (mv >= bscc_pkg::VOLT_MV[i]) && (mv < bscc_pkg::VOLT_MV[i+1])) begin
          sel_found = 1'b1;
          sel_num   = mv - bscc_pkg::VOLT_MV[i];
          sel_span  = bscc_pkg::VOLT_MV[i+1] - bscc_pkg::VOLT_MV[i];
          sel_dpct  = bscc_pkg::PCT_UPCT[i+1] - bscc_pkg::PCT_UPCT[i];
          sel_base  = bscc_pkg::PCT_UPCT[i];
        end
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cap       <= 12'd100;
      band_low  <= 17'd1000;
      band_high <= 17'd2000;
      rest_time <= 20'd20000;
      gate_cur  <= -18'sd2000;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bscc_pkg::CFG_CAPACITY:  cap       <= cfg_data[bscc_pkg::CAP_W-1:0];
        bscc_pkg::CFG_BAND_LOW:  band_low  <= cfg_data[bscc_pkg::BAND_W-1:0];
        bscc_pkg::CFG_BAND_HIGH: band_high <= cfg_data[bscc_pkg::BAND_W-1:0];
        bscc_pkg::CFG_REST_TIME: rest_time <= cfg_data[bscc_pkg::REST_W-1:0];
        bscc_pkg::CFG_GATE:      gate_cur  <= $signed(cfg_data[bscc_pkg::GATE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Persistent SoC and stability state
  always_ff @(posedge clk) begin
    if (rst) begin
      soc          <= '0;
      prior_time   <= '0;
      prior_cur    <= '0;
      stable_flag  <= 1'b0;
      stable_start <= '0;
    end else begin
      if (cfg_wr_en && (cfg_index == bscc_pkg::CFG_INIT_SOC)) begin
        soc <= (cfg_data > bscc_pkg::SOC_FULL) ? bscc_pkg::SOC_FULL : cfg_data;
      end
      case (cmd.op)
        bscc_pkg::OP_LOAD: begin
          prior_time <= now_ms;
        end
        bscc_pkg::OP_APPLY_CHARGE: begin
          soc <= soc_chg;
        end
        bscc_pkg::OP_GATE: begin
          if (cur_gt) begin
            prior_cur <= cur;
            if (in_band) begin
              if (!stable_flag) begin
                stable_flag  <= 1'b1;
                stable_start <= now;
              end
            end else begin
              stable_flag <= 1'b0;
            end
          end
        end
        bscc_pkg::OP_APPLY_BLEND: begin
          soc <= div_q[bscc_pkg::SOC_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Working registers for the transaction in flight
  always_ff @(posedge clk) begin
    case (cmd.op)
      bscc_pkg::OP_LOAD: begin
        cur     <= current_ma;
        now     <= now_ms;
        mv      <= battery_voltage_mv;
        elapsed <= now_ms - prior_time;
        mag     <= mag_in;
        vdiv    <= {2'b00, vdiv36};
        corr    <= 1'b0;
      end
      bscc_pkg::OP_MUL_LO: begin
        acc <= {5'd0, mul_p};
      end
      bscc_pkg::OP_MUL_HI: begin
        acc <= acc + {mul_p[35:0], 16'd0};
      end
      bscc_pkg::OP_GATE: begin
        corr <= cur_gt && in_band && stable_flag && rest_ok;
      end
      bscc_pkg::OP_TBL_SEL: begin
        tbl_num  <= sel_num;
        tbl_span <= sel_span;
        tbl_dpct <= sel_dpct;
        tbl_base <= sel_base;
      end
      bscc_pkg::OP_TBL_MUL: begin
        acc <= {5'd0, mul_p};
      end
      bscc_pkg::OP_APPLY_TABLE: begin
        tbl_val <= tbl_base + div_q[bscc_pkg::SOC_W-1:0];
      end
      bscc_pkg::OP_APPLY_WHOLE: begin
        whole <= div_q[bscc_pkg::WHOLE_W-1:0];
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == bscc_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == bscc_pkg::OP_OUT) begin
      soc_micro_pct <= soc;
      soc_whole_pct <= whole;
      at_rest       <= stable_flag;
      corrected     <= corr;
    end
  end

  // Status back to the controller
  assign status.div_done = div_done;
  assign status.corr_now = cur_gt && in_band && stable_flag && rest_ok;
  assign status.out_busy = out_valid && out_stall;

endmodule

>>> rtl/bscc_ctrl.sv
// Controller state machine that sequences the datapath for one sample.
`timescale 1ns / 1ps

module bscc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  bscc_pkg::dp_status_t   status,
  output bscc_pkg::dp_cmd_t      cmd,
  output logic                   in_stall
);

  bscc_pkg::ctrl_state_t state;
  bscc_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bscc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      bscc_pkg::ST_IDLE:       if (in_valid) state_next = bscc_pkg::ST_MUL_LO;
      bscc_pkg::ST_MUL_LO:     state_next = bscc_pkg::ST_MUL_HI;
      bscc_pkg::ST_MUL_HI:     state_next = bscc_pkg::ST_DIV_CHG;
      bscc_pkg::ST_DIV_CHG:    state_next = bscc_pkg::ST_WAIT_CHG;
      bscc_pkg::ST_WAIT_CHG:   if (status.div_done) state_next = bscc_pkg::ST_GATE;
      bscc_pkg::ST_GATE: begin
        state_next = status.corr_now ? bscc_pkg::ST_TBL_SEL : bscc_pkg::ST_DIV_WHOLE;
      end
      bscc_pkg::ST_TBL_SEL:    state_next = bscc_pkg::ST_TBL_MUL;
      bscc_pkg::ST_TBL_MUL:    state_next = bscc_pkg::ST_DIV_TBL;
      bscc_pkg::ST_DIV_TBL:    state_next = bscc_pkg::ST_WAIT_TBL;
      bscc_pkg::ST_WAIT_TBL:   if (status.div_done) state_next = bscc_pkg::ST_DIV_BLEND;
      bscc_pkg::ST_DIV_BLEND:  state_next = bscc_pkg::ST_WAIT_BLEND;
      bscc_pkg::ST_WAIT_BLEND: if (status.div_done) state_next = bscc_pkg::ST_DIV_WHOLE;
      bscc_pkg::ST_DIV_WHOLE:  state_next = bscc_pkg::ST_WAIT_WHOLE;
      bscc_pkg::ST_WAIT_WHOLE: if (status.div_done) state_next = bscc_pkg::ST_OUT;
      bscc_pkg::ST_OUT:        if (!status.out_busy) state_next = bscc_pkg::ST_IDLE;
      default:                 state_next = bscc_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd.op   = bscc_pkg::OP_NONE;
    in_stall = 1'b1;
    case (state)
      bscc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) cmd.op = bscc_pkg::OP_LOAD;
      end
      bscc_pkg::ST_MUL_LO:    cmd.op = bscc_pkg::OP_MUL_LO;
      bscc_pkg::ST_MUL_HI:    cmd.op = bscc_pkg::OP_MUL_HI;
      bscc_pkg::ST_DIV_CHG:   cmd.op = bscc_pkg::OP_DIV_CHARGE;
      bscc_pkg::ST_WAIT_CHG:  if (status.div_done) cmd.op = bscc_pkg::OP_APPLY_CHARGE;
      bscc_pkg::ST_GATE:      cmd.op = bscc_pkg::OP_GATE;
      bscc_pkg::ST_TBL_SEL:   cmd.op = bscc_pkg::OP_TBL_SEL;
      bscc_pkg::ST_TBL_MUL:   cmd.op = bscc_pkg::OP_TBL_MUL;
      bscc_pkg::ST_DIV_TBL:   cmd.op = bscc_pkg::OP_DIV_TABLE;
      bscc_pkg::ST_WAIT_TBL:  if (status.div_done) cmd.op = bscc_pkg::OP_APPLY_TABLE;
      bscc_pkg::ST_DIV_BLEND: cmd.op = bscc_pkg::OP_DIV_BLEND;
      bscc_pkg::ST_WAIT_BLEND: begin
        if (status.div_done) cmd.op = bscc_pkg::OP_APPLY_BLEND;
      end
      bscc_pkg::ST_DIV_WHOLE: cmd.op = bscc_pkg::OP_DIV_WHOLE;
      bscc_pkg::ST_WAIT_WHOLE: begin
        if (status.div_done) cmd.op = bscc_pkg::OP_APPLY_WHOLE;
      end
      bscc_pkg::ST_OUT:       if (!status.out_busy) cmd.op = bscc_pkg::OP_OUT;
      default:                cmd.op = bscc_pkg::OP_NONE;
    endcase
  end

endmodule
